>>> rtl/msb_pkg.sv
`default_nettype none

package msb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int FRAME_BYTES   = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
	localparam int FB_AW         = $clog2(FRAME_BYTES);
	localparam int PIX_W         = FB_AW + 3;
	localparam int X_W           = $clog2(SCREEN_WIDTH);
	localparam int Y_W           = $clog2(SCREEN_HEIGHT);

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_REJECT = 2'd1;
	localparam logic [1:0] STAT_NOBLIT = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [7:0] sprite_width;
		logic [7:0] sprite_height;
		logic [7:0] sprite_byte;
		logic [9:0] read_address;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       blit_done;
		logic [7:0] read_data;
	} rsp_t;

	// one sprite word split over two framebuffer bytes
	typedef struct packed {
		logic             active;
		logic             reject;
		logic [FB_AW-1:0] idx;
		logic [7:0]       mask_hi;
		logic [7:0]       data_hi;
		logic [7:0]       mask_lo;
		logic [7:0]       data_lo;
		logic             done;
	} blit_cmd_t;

endpackage

`default_nettype wire

>>> rtl/msb_ram.sv
`default_nettype none

module msb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/msb_blit_ctrl.sv
`default_nettype none

module msb_blit_ctrl import msb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start_en,
	input  wire logic data_en,
	input  wire req_t req,
	output blit_cmd_t cmd
);

	logic [X_W-1:0] origin_x_q;
	logic [Y_W-1:0] origin_y_q;
	logic [7:0]     width_q;
	logic [7:0]     height_q;
	logic [7:0]     row_q;
	logic [4:0]     byte_q;
	logic           active_q;

	logic [8:0]       x_end;
	logic [8:0]       y_end;
	logic [7:0]       col;
	logic [7:0]       rem;
	logic [7:0]       mask8;
	logic [Y_W-1:0]   row_y;
	logic [PIX_W-1:0] pix;
	logic [15:0]      mask16;
	logic [15:0]      data16;
	logic             row_last;
	logic             blit_last;

	always_comb begin
		x_end = {1'b0, req.x_pos} + {1'b0, req.sprite_width};
		y_end = {1'b0, req.y_pos} + {1'b0, req.sprite_height};
		col   = {byte_q, 3'b000};
		rem   = width_q - col;
		// padding bits past the sprite width stay untouched
		mask8 = (rem >= 8'd8) ? 8'hFF : ~(8'hFF >> rem[2:0]);
		row_y = origin_y_q + row_q[Y_W-1:0];
		pix   = PIX_W'(row_y) * PIX_W'(SCREEN_WIDTH) + PIX_W'(origin_x_q) + PIX_W'(col);
		mask16 = {mask8, 8'h00} >> pix[2:0];
		data16 = {req.sprite_byte & mask8, 8'h00} >> pix[2:0];
		row_last  = ({1'b0, col} + 9'd8) >= {1'b0, width_q};
		blit_last = row_last && (({1'b0, row_q} + 9'd1) >= {1'b0, height_q});

		cmd.active  = active_q;
		cmd.reject  = (req.sprite_width == 8'd0) || (req.sprite_height == 8'd0) ||
			(x_end > 9'(SCREEN_WIDTH)) || (y_end > 9'(SCREEN_HEIGHT));
		cmd.idx     = pix[PIX_W-1:3];
		cmd.mask_hi = mask16[15:8];
		cmd.data_hi = data16[15:8];
		cmd.mask_lo = mask16[7:0];
		cmd.data_lo = data16[7:0];
		cmd.done    = blit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			row_q      <= '0;
			byte_q     <= '0;
			active_q   <= 1'b0;
		end else if (start_en) begin
			if (cmd.reject) begin
				active_q <= 1'b0;
			end else begin
				origin_x_q <= req.x_pos[X_W-1:0];
				origin_y_q <= req.y_pos[Y_W-1:0];
				width_q    <= req.sprite_width;
				height_q   <= req.sprite_height;
				row_q      <= '0;
				byte_q     <= '0;
				active_q   <= 1'b1;
			end
		end else if (data_en && active_q) begin
			if (row_last) begin
				byte_q <= '0;
				if (blit_last) begin
					row_q    <= '0;
					active_q <= 1'b0;
				end else begin
					row_q <= row_q + 8'd1;
				end
			end else begin
				byte_q <= byte_q + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/mono_sprite_blitter_unit.sv
// Flow: start, unused and ignored items give their result word straight from ST_IDLE on
// accept; reads pass through ST_RDOUT, sprite words through ST_WR0 and also ST_WR1 when
// the word straddles two framebuffer bytes. Items are taken one at a time, paced by the
// read-modify-write of each framebuffer byte through the one write port.
// A finished result waits in the output register while the next item is taken.
// Reset: arst_n clears control and blit state, then a sweep over all FRAME_BYTES (1024)
// framebuffer bytes zeroes them; req_stall stays high during the sweep.
`default_nettype none

module mono_sprite_blitter_unit import msb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WR0   = 3'd2;
	localparam logic [2:0] ST_WR1   = 3'd3;
	localparam logic [2:0] ST_RDOUT = 3'd4;
	localparam logic [2:0] ST_PUSH  = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [FB_AW-1:0] clr_q;
	blit_cmd_t        cmd;
	blit_cmd_t        cmd_s1;
	logic             oor_s1;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             req_acc;
	logic             rsp_free;
	logic             emit;
	rsp_t             emit_val;
	logic             ram_we;
	logic [FB_AW-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic [FB_AW-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic [FB_AW-1:0] idx_next;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign idx_next  = cmd_s1.idx + FB_AW'(1);

	msb_blit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start_en (req_acc && (req.kind == KIND_START)),
		.data_en  (req_acc && (req.kind == KIND_DATA)),
		.req      (req),
		.cmd      (cmd)
	);

	msb_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cmd_s1.idx;
		ram_wdata = 8'h00;
		ram_raddr = cmd.idx;
		emit      = 1'b0;
		emit_val  = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == FB_AW'(FRAME_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_acc) begin
					case (req.kind)
						KIND_START: begin
							emit            = 1'b1;
							emit_val.status = cmd.reject ? STAT_REJECT : STAT_OK;
						end
						KIND_DATA: begin
							if (cmd.active) begin
								state_d = ST_WR0;
							end else begin
								emit            = 1'b1;
								emit_val.status = STAT_NOBLIT;
							end
						end
						KIND_READ: begin
							ram_raddr = FB_AW'(req.read_address);
							state_d   = ST_RDOUT;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			ST_WR0: begin
				ram_we    = 1'b1;
				ram_wdata = (ram_rdata & ~cmd_s1.mask_hi) | cmd_s1.data_hi;
				if (cmd_s1.mask_lo != 8'h00) begin
					ram_raddr = idx_next;
					state_d   = ST_WR1;
				end else begin
					emit               = 1'b1;
					emit_val.blit_done = cmd_s1.done;
				end
			end
			ST_WR1: begin
				ram_we             = 1'b1;
				ram_waddr          = idx_next;
				ram_wdata          = (ram_rdata & ~cmd_s1.mask_lo) | cmd_s1.data_lo;
				emit               = 1'b1;
				emit_val.blit_done = cmd_s1.done;
			end
			ST_RDOUT: begin
				emit               = 1'b1;
				emit_val.read_data = oor_s1 ? 8'h00 : ram_rdata;
			end
			ST_PUSH: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (emit) begin
			state_d = rsp_free ? ST_IDLE : ST_PUSH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + FB_AW'(1);
			end
			if ((emit || (state_q == ST_PUSH)) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.kind == KIND_DATA)) begin
			cmd_s1 <= cmd;
		end
		if (req_acc && (req.kind == KIND_READ)) begin
			oor_s1 <= {22'd0, req.read_address} >= 32'(FRAME_BYTES);
		end
		if (emit && !rsp_free) begin
			res_q <= emit_val;
		end
		if (emit && rsp_free) begin
			rsp_q <= emit_val;
		end else if ((state_q == ST_PUSH) && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("framebuffer written while idle");

	a_push_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> rsp_valid_q)
		else $error("pending word without a word on the output");

	a_wr1_after_wr0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR1) |-> ($past(state_q) == ST_WR0))
		else $error("second byte write without first");

	a_data_starts_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.kind == KIND_DATA) && cmd.active) |=> (state_q == ST_WR0))
		else $error("sprite word did not start read-modify-write");

endmodule

`default_nettype wire

>>> test/mono_sprite_blitter_unit_test.sv
`timescale 1ns / 100ps

module mono_sprite_blitter_unit_test;
	import msb_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_TICKS = 8;
	localparam int PRINT_CAP    = 50;
	localparam int NUM_SCRIPT   = 27;
	localparam int HOLD_TICKS   = 400;

	typedef struct {
		req_t word;
		bit   fixed;
		rsp_t want;
	} script_row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// shadow copy of the blitter state
	logic [7:0]       fb_model [FRAME_BYTES];
	logic [X_W-1:0]   org_x;
	logic [Y_W-1:0]   org_y;
	logic [7:0]       spr_w;
	logic [7:0]       spr_h;
	logic [7:0]       row_idx;
	logic [4:0]       col_byte;
	logic             blit_on;

	rsp_t        expected_rsp [$];
	script_row_t script [NUM_SCRIPT];
	int          idle_pct;
	int          stall_pct;
	int          hold_req;
	int          hold_seen;
	int          hold_left;
	int          items_sent;
	int          mismatches;
	int          cycle_count;

	mono_sprite_blitter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rsp_t blit_predict(req_t w);
		rsp_t r;
		int   per_row;
		int   col;
		int   pix;
		r = '0;
		case (w.kind)
			KIND_START: begin
				if (w.sprite_width == 0 || w.sprite_height == 0 ||
				    int'(w.x_pos) + int'(w.sprite_width) > SCREEN_WIDTH ||
				    int'(w.y_pos) + int'(w.sprite_height) > SCREEN_HEIGHT) begin
					r.status = STAT_REJECT;
					blit_on  = 1'b0;
				end else begin
					org_x    = w.x_pos[X_W-1:0];
					org_y    = w.y_pos[Y_W-1:0];
					spr_w    = w.sprite_width;
					spr_h    = w.sprite_height;
					row_idx  = '0;
					col_byte = '0;
					blit_on  = 1'b1;
				end
			end
			KIND_DATA: begin
				if (!blit_on) begin
					r.status = STAT_NOBLIT;
				end else begin
					per_row = (int'(spr_w) + 7) >> 3;
					for (int k = 0; k < 8; k++) begin
						col = int'(col_byte) * 8 + k;
						if (col < int'(spr_w)) begin
							pix = SCREEN_WIDTH * (int'(org_y) + int'(row_idx)) +
							      int'(org_x) + col;
							fb_model[pix >> 3][7 - (pix & 7)] = w.sprite_byte[7 - k];
						end
					end
					col_byte = col_byte + 1'b1;
					if (int'(col_byte) >= per_row) begin
						col_byte = '0;
						row_idx  = row_idx + 1'b1;
						if (row_idx >= spr_h) begin
							blit_on     = 1'b0;
							row_idx     = '0;
							r.blit_done = 1'b1;
						end
					end
				end
			end
			KIND_READ: begin
				if (int'(w.read_address) < FRAME_BYTES)
					r.read_data = fb_model[w.read_address];
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic req_t noise_word(logic [1:0] kind);
		logic [63:0] bits;
		req_t        w;
		bits   = {$urandom, $urandom};
		w      = bits[$bits(req_t)-1:0];
		w.kind = kind;
		return w;
	endfunction

	function automatic script_row_t make_row(logic [1:0] kind, int x, int y, int w, int h,
	                                         int b, int a, bit fixed,
	                                         logic [1:0] st, bit dn, int rd);
		script_row_t s;
		s.word.kind          = kind;
		s.word.x_pos         = x[7:0];
		s.word.y_pos         = y[7:0];
		s.word.sprite_width  = w[7:0];
		s.word.sprite_height = h[7:0];
		s.word.sprite_byte   = b[7:0];
		s.word.read_address  = a[9:0];
		s.fixed              = fixed;
		s.want.status        = st;
		s.want.blit_done     = dn;
		s.want.read_data     = rd[7:0];
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)",
			         what, got, want, cycle_count);
		mismatches++;
	endtask

	// offer one word, hold it until taken, then log what should come back
	task automatic issue_word(req_t w, bit fixed, rsp_t fixed_want);
		rsp_t want;
		bit   ignored;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		ignored = (w.kind == KIND_DATA) && !blit_on;
		want    = blit_predict(w);
		expected_rsp.push_back(fixed ? fixed_want : want);
		if (!ignored)
			items_sent++;
	endtask

	task automatic issue_random(req_t w);
		issue_word(w, 1'b0, '0);
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// start plus its full set of sprite words, with reads mixed in; now and then cut short
	task automatic run_blit;
		int   w;
		int   h;
		int   x;
		int   y;
		int   n;
		int   cut;
		int   base;
		req_t s;
		if ($urandom_range(9) == 0) begin
			w = $urandom_range(1, SCREEN_WIDTH);
			h = $urandom_range(1, 4);
		end else if ($urandom_range(9) == 0) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, SCREEN_HEIGHT);
		end else begin
			w = $urandom_range(1, 20);
			h = $urandom_range(1, 6);
		end
		x = $urandom_range(0, SCREEN_WIDTH - w);
		y = $urandom_range(0, SCREEN_HEIGHT - h);
		s = noise_word(KIND_START);
		s.x_pos         = x[7:0];
		s.y_pos         = y[7:0];
		s.sprite_width  = w[7:0];
		s.sprite_height = h[7:0];
		issue_random(s);
		n    = ((w + 7) >> 3) * h;
		cut  = ($urandom_range(19) == 0) ? $urandom_range(0, n - 1) : n;
		base = (SCREEN_WIDTH * y + x) >> 3;
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(9) == 0) begin
				s = noise_word(KIND_READ);
				s.read_address = 10'((base + $urandom_range(0, 16 * h)) % FRAME_BYTES);
				issue_random(s);
			end
			s = noise_word(KIND_DATA);
			issue_random(s);
		end
	endtask

	task automatic run_random(int n);
		int   target;
		int   pick;
		req_t s;
		target = items_sent + n;
		while (items_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				run_blit();
			end else if (pick < 80) begin
				issue_random(noise_word(KIND_START));
			end else if (pick < 90) begin
				issue_random(noise_word(KIND_READ));
			end else if (pick < 95) begin
				issue_random(noise_word(KIND_UNUSED));
			end else begin
				s = noise_word(KIND_DATA);
				issue_random(s);
			end
		end
	endtask

	task automatic run_phase(int idle, int stall, int n);
		idle_pct  = idle;
		stall_pct = stall;
		run_random(n);
		drain();
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver side: a long hold-off takes priority over random stalls
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_TICKS - 1;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("word with nothing pending", int'(rsp), 0);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.blit_done !== want.blit_done)
					report_mismatch("blit_done", int'(rsp.blit_done), int'(want.blit_done));
				if (rsp.read_data !== want.read_data)
					report_mismatch("read_data", int'(rsp.read_data), int'(want.read_data));
			end
		end
	end

	initial begin
		foreach (fb_model[i])
			fb_model[i] = 8'h00;
		org_x     = '0;
		org_y     = '0;
		spr_w     = '0;
		spr_h     = '0;
		row_idx   = '0;
		col_byte  = '0;
		blit_on   = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 0;

		// directed rows: typed expectations where obvious, else the predictor
		script[0]  = make_row(KIND_READ,   0, 0, 0, 0, 0, 0,    1, STAT_OK, 0, 0);
		script[1]  = make_row(KIND_READ,   0, 0, 0, 0, 0, 1023, 1, STAT_OK, 0, 0);
		script[2]  = make_row(KIND_DATA,   0, 0, 0, 0, 255, 0,  1, STAT_NOBLIT, 0, 0);
		script[3]  = make_row(KIND_UNUSED, 255, 255, 255, 255, 255, 1023,
		                      1, STAT_OK, 0, 0);
		script[4]  = make_row(KIND_START,  0, 0, 0, 1, 0, 0,    1, STAT_REJECT, 0, 0);
		script[5]  = make_row(KIND_START,  0, 0, 1, 0, 0, 0,    1, STAT_REJECT, 0, 0);
		script[6]  = make_row(KIND_START,  1, 0, 128, 1, 0, 0,  1, STAT_REJECT, 0, 0);
		script[7]  = make_row(KIND_START,  0, 1, 1, 64, 0, 0,   1, STAT_REJECT, 0, 0);
		script[8]  = make_row(KIND_START,  255, 255, 255, 255, 0, 0,
		                      1, STAT_REJECT, 0, 0);
		script[9]  = make_row(KIND_START,  0, 0, 128, 64, 0, 0, 1, STAT_OK, 0, 0);
		script[10] = make_row(KIND_DATA,   0, 0, 0, 0, 8'hA5, 0, 0, STAT_OK, 0, 0);
		script[11] = make_row(KIND_READ,   0, 0, 0, 0, 0, 0,    0, STAT_OK, 0, 0);
		// new start abandons the full-screen blit
		script[12] = make_row(KIND_START,  127, 63, 1, 1, 0, 0, 1, STAT_OK, 0, 0);
		script[13] = make_row(KIND_DATA,   0, 0, 0, 0, 255, 0,  1, STAT_OK, 1, 0);
		script[14] = make_row(KIND_READ,   0, 0, 0, 0, 0, 1023, 1, STAT_OK, 0, 8'h01);
		script[15] = make_row(KIND_DATA,   0, 0, 0, 0, 8'h3C, 0, 1, STAT_NOBLIT, 0, 0);
		// 10-wide rows: padding bits in every second word
		script[16] = make_row(KIND_START,  3, 2, 10, 2, 0, 0,   1, STAT_OK, 0, 0);
		script[17] = make_row(KIND_DATA,   0, 0, 0, 0, 8'hFF, 0, 0, STAT_OK, 0, 0);
		script[18] = make_row(KIND_DATA,   0, 0, 0, 0, 8'hFF, 0, 0, STAT_OK, 0, 0);
		script[19] = make_row(KIND_DATA,   0, 0, 0, 0, 8'h00, 0, 0, STAT_OK, 0, 0);
		script[20] = make_row(KIND_DATA,   0, 0, 0, 0, 8'h7F, 0, 0, STAT_OK, 0, 0);
		script[21] = make_row(KIND_READ,   0, 0, 0, 0, 0, 32,   0, STAT_OK, 0, 0);
		script[22] = make_row(KIND_READ,   0, 0, 0, 0, 0, 33,   0, STAT_OK, 0, 0);
		// a rejected start also ends the open blit
		script[23] = make_row(KIND_START,  0, 0, 8, 1, 0, 0,    1, STAT_OK, 0, 0);
		script[24] = make_row(KIND_START,  0, 0, 0, 0, 0, 0,    1, STAT_REJECT, 0, 0);
		script[25] = make_row(KIND_DATA,   0, 0, 0, 0, 8'h55, 0, 1, STAT_NOBLIT, 0, 0);
		script[26] = make_row(KIND_READ,   0, 0, 0, 0, 0, 0,    0, STAT_OK, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			issue_word(script[i].word, script[i].fixed, script[i].want);
		drain();

		run_phase(0, 0, 100);
		run_phase(70, 0, 100);
		run_phase(0, 70, 100);
		run_phase(17, 17, 100);

		// receiver holds off long enough for the block to back up into its input
		hold_req++;
		run_phase(0, 0, 60);

		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/msb_pkg.sv
rtl/msb_ram.sv
rtl/msb_blit_ctrl.sv
rtl/mono_sprite_blitter_unit.sv
test/mono_sprite_blitter_unit_test.sv
